// ----- sv/pra_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pra_pkg: shared constants and types for the protection region allocator
// Sizes, op codes, status codes, priority codes, config byte modes and states.
// ----------------------------------------------------------------------------
package pra_pkg;
  localparam int NUM_REGIONS = 16;
  localparam int NUM_ENTRIES = 16;
  localparam int PAGE_BITS   = 12;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_FREE  = 3'd1;
  localparam logic [2:0] OP_CALC  = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_SIZE    = 3'd2;
  localparam logic [2:0] ST_OVERLAP = 3'd3;
  localparam logic [2:0] ST_ALIGN   = 3'd4;
  localparam logic [2:0] ST_TOR     = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  localparam logic [1:0] PR_ANY    = 2'd0;
  localparam logic [1:0] PR_TOP    = 2'd1;
  localparam logic [1:0] PR_BOTTOM = 2'd2;

  localparam logic [7:0] MODE_TOR   = 8'h08;
  localparam logic [7:0] MODE_NAPOT = 8'h18;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_ALLOC = 5'b00100,
    S_EXEC  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;
endpackage
`default_nettype wire

// ----- sv/pmp_region_allocator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmp_region_allocator_core: protection region table and entry allocator
// Init, free, entry encode, overlap query and read of protection regions.
// ----------------------------------------------------------------------------
// One item is taken while busy is low and start is high. Init and query walk
// the sixteen-region table one region a cycle through a single shared
// compare unit, then go through allocate and done; free, encode and read
// go through exec and done. The result stands one cycle with done high;
// it cannot be held off. The table has no clearing pass: valid bits gate it.
module pmp_region_allocator_core
  import pra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic [2:0]  op,
  input  wire logic [63:0] base_addr,
  input  wire logic [63:0] length,
  input  wire logic [1:0]  priority_req,
  input  wire logic        shareable,
  input  wire logic [3:0]  region_sel,
  input  wire logic [2:0]  perm,
  output logic [2:0]       status,
  output logic [3:0]       alloc_id,
  output logic             overlap_found,
  output logic [3:0]       first_entry,
  output logic [7:0]       first_cfg,
  output logic [63:0]      first_addr,
  output logic             second_valid,
  output logic [3:0]       second_entry,
  output logic [63:0]      second_addr,
  output logic [63:0]      region_base,
  output logic [63:0]      region_length
);
  localparam int RW = $clog2(NUM_REGIONS);
  localparam int EW = $clog2(NUM_ENTRIES);
  localparam logic [63:0] PMASK = (64'd1 << PAGE_BITS) - 64'd1;

  state_t state;
  logic [NUM_REGIONS-1:0] region_valid_map;
  logic [NUM_ENTRIES-1:0] entry_used_map;
  logic [63:0] region_start [NUM_REGIONS];
  logic [63:0] region_size  [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] region_napot_bits;
  logic [NUM_REGIONS-1:0] region_may_overlap;
  logic [EW-1:0] region_entry [NUM_REGIONS];

  // latched item
  logic [2:0]  op_q;
  logic [63:0] base_q, len_q;
  logic [1:0]  pr_q;
  logic        share_q;
  logic [3:0]  sel_q;
  logic [2:0]  perm_q;
  logic [RW:0] idx;
  logic        hit;

  // registered table read for free/encode/read
  logic [63:0] rd_start, rd_size;
  logic [EW-1:0] rd_entry;
  logic        rd_napot;

  // shared compare unit: one region against the item range
  logic [64:0] end_sum;
  logic [63:0] end_q;
  logic        ovf;
  logic [RW-1:0] ci;
  logic        cmp_hit;
  assign end_sum = {1'b0, base_q} + {1'b0, len_q};
  assign end_q   = end_sum[63:0];
  assign ovf     = end_sum[64];
  assign ci      = idx[RW-1:0];
  assign cmp_hit = region_valid_map[ci] && !region_may_overlap[ci] &&
                   (region_start[ci] < end_q) &&
                   ((region_start[ci] + region_size[ci]) > base_q);

  // init decisions, evaluated in the allocate cycle
  logic [1:0] pr_eff;
  logic napot, sel_ok;
  logic [RW-1:0] free_r;
  logic          free_r_ok;
  logic [EW-1:0] free_e, free_p;
  logic          free_e_ok, free_p_ok;
  logic [2:0]    init_status;
  logic          do_alloc;
  logic [EW-1:0] alloc_entry;
  logic [NUM_ENTRIES-1:0] alloc_mask, free_mask;
  logic [EW-1:0] sel_entry;
  logic [63:0]   calc_addr;
  logic          calc_ok, read_ok, pair_ok, bad_sel;
  assign pr_eff = (pr_q == 2'd3) ? PR_ANY : pr_q;
  assign napot  = (len_q == '1 && base_q == '0) ||
                  ((len_q & (len_q - 64'd1)) == '0 && (base_q & (len_q - 64'd1)) == '0);
  assign sel_ok = ({1'b0, sel_q} < 5'(NUM_REGIONS)) && region_valid_map[sel_q[RW-1:0]];
  assign sel_entry = region_entry[sel_q[RW-1:0]];
  assign do_alloc  = (op_q == OP_INIT) && (init_status == ST_OK);
  assign bad_sel   = (op_q inside {OP_FREE, OP_CALC, OP_READ}) && !hit;
  assign calc_ok   = (op_q == OP_CALC) && hit;
  assign read_ok   = (op_q == OP_READ) && hit;
  assign pair_ok   = calc_ok && !rd_napot && rd_entry != '0;

  always_comb begin
    free_r = '0; free_r_ok = 1'b0;
    for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
      if (!region_valid_map[i]) begin
        free_r = RW'(i); free_r_ok = 1'b1;
      end
    end
    free_e = '0; free_e_ok = 1'b0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_used_map[i]) begin
        free_e = EW'(i); free_e_ok = 1'b1;
      end
    end
    free_p = '0; free_p_ok = 1'b0;
    for (int i = NUM_ENTRIES - 2; i >= 0; i--) begin
      if (!entry_used_map[i] && !entry_used_map[i+1]) begin
        free_p = EW'(i); free_p_ok = 1'b1;
      end
    end
  end

  // init checks in priority order
  always_comb begin
    init_status = ST_OK;
    if (len_q == '0) begin
      init_status = ST_SIZE;
    end else if (!share_q && (hit || ovf)) begin
      init_status = ST_OVERLAP;
    end else if ((len_q != '1 && (len_q & PMASK) != '0) || (base_q & PMASK) != '0) begin
      init_status = ST_ALIGN;
    end else if (!napot && pr_eff != PR_ANY && !(pr_eff == PR_TOP && base_q == '0)) begin
      init_status = ST_TOR;
    end else if (!free_r_ok) begin
      init_status = ST_FULL;
    end else if (pr_eff == PR_TOP && entry_used_map[0]) begin
      init_status = ST_FULL;
    end else if (pr_eff == PR_ANY && napot && !free_e_ok) begin
      init_status = ST_FULL;
    end else if (pr_eff == PR_ANY && !napot && !free_p_ok) begin
      init_status = ST_FULL;
    end
  end

  // entries taken by init and released by free
  always_comb begin
    alloc_entry = '0;
    alloc_mask  = '0;
    if (pr_eff == PR_TOP) begin
      alloc_mask[0] = 1'b1;
    end else if (pr_eff == PR_BOTTOM) begin
      alloc_entry = EW'(NUM_ENTRIES - 1);
      alloc_mask[NUM_ENTRIES-1] = 1'b1;
    end else if (napot) begin
      alloc_entry = free_e;
      alloc_mask[free_e] = 1'b1;
    end else begin
      alloc_entry = free_p + 1'b1;
      alloc_mask[free_p] = 1'b1;
      alloc_mask[free_p + 1'b1] = 1'b1;
    end
    free_mask = '0;
    free_mask[sel_entry] = 1'b1;
    if (!region_napot_bits[sel_q[RW-1:0]] && sel_entry != '0)
      free_mask[sel_entry - 1'b1] = 1'b1;
  end

  // encoded address word of the selected region
  always_comb begin
    if (rd_start == '0 && rd_size == '1) calc_addr = '1;
    else if (rd_napot) calc_addr = (rd_start | ((rd_size >> 1) - 64'd1)) >> 2;
    else calc_addr = (rd_start + rd_size) >> 2;
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      region_valid_map <= '0;
      entry_used_map <= '0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q <= op; base_q <= base_addr; len_q <= length;
            pr_q <= priority_req; share_q <= shareable;
            sel_q <= region_sel; perm_q <= perm;
            idx <= '0; hit <= 1'b0;
            if (op == OP_INIT || op == OP_QUERY) state <= S_SCAN;
            else state <= S_EXEC;
          end
        end
        S_SCAN: begin
          // walk one region a cycle
          if (cmp_hit) hit <= 1'b1;
          if (idx == (RW+1)'(NUM_REGIONS - 1)) state <= S_ALLOC;
          idx <= idx + 1'b1;
        end
        S_ALLOC: begin
          // latch the init or query answer, commit an accepted init
          status <= (op_q == OP_QUERY) ? ST_OK : init_status;
          alloc_id <= do_alloc ? 4'(free_r) : 4'd0;
          overlap_found <= (op_q == OP_QUERY) && (hit || ovf);
          first_entry <= '0; first_cfg <= '0; first_addr <= '0;
          second_valid <= 1'b0; second_entry <= '0; second_addr <= '0;
          region_base <= '0; region_length <= '0;
          if (do_alloc) begin
            region_valid_map[free_r] <= 1'b1;
            entry_used_map <= entry_used_map | alloc_mask;
            region_start[free_r] <= base_q;
            region_size[free_r] <= len_q;
            region_napot_bits[free_r] <= napot;
            region_may_overlap[free_r] <= share_q;
            region_entry[free_r] <= alloc_entry;
          end
          state <= S_DONE;
        end
        S_EXEC: begin
          // table read registered and free committed here; the done state answers
          rd_start <= region_start[sel_q[RW-1:0]];
          rd_size  <= region_size[sel_q[RW-1:0]];
          rd_entry <= sel_entry;
          rd_napot <= region_napot_bits[sel_q[RW-1:0]];
          hit <= sel_ok;
          if (op_q == OP_FREE && sel_ok) begin
            region_valid_map[sel_q[RW-1:0]] <= 1'b0;
            entry_used_map <= entry_used_map & ~free_mask;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
          if (op_q != OP_INIT && op_q != OP_QUERY) begin
            status <= bad_sel ? ST_INVALID : ST_OK;
            alloc_id <= '0;
            overlap_found <= 1'b0;
            first_entry <= calc_ok ? 4'(rd_entry) : 4'd0;
            first_cfg <= calc_ok ? ((rd_napot ? MODE_NAPOT : MODE_TOR) | {5'd0, perm_q})
                                 : 8'd0;
            first_addr <= calc_ok ? calc_addr : 64'd0;
            second_valid <= pair_ok;
            second_entry <= pair_ok ? 4'(rd_entry - 1'b1) : 4'd0;
            second_addr <= pair_ok ? (rd_start >> 2) : 64'd0;
            region_base <= read_ok ? rd_start : 64'd0;
            region_length <= read_ok ? rd_size : 64'd0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");
  a_second: assert property (@(posedge clk) disable iff (rst)
    (done && second_valid) |-> (first_cfg[4:3] == 2'b01)) else $error("pair on NAPOT");
endmodule
`default_nettype wire
